// ----- rtl/core/sdd_pkg.sv -----
// Shared constants, types and register codes for the second difference edge detector.
// Used by every module of the block; depends on nothing else.
package sdd_pkg;

    // Filter and slice limits.
    localparam int MAX_HALF_WIDTH   = 16;
    localparam int MAX_SLICE_LENGTH = 4096;
    localparam int CELL_COUNT       = 2 * MAX_HALF_WIDTH;
    localparam int CELL_IDX_W       = $clog2(CELL_COUNT);

    // Field widths.
    localparam int SAMPLE_W = 20;
    localparam int HW_W     = 5;
    localparam int THR_W    = 21;
    localparam int DIFF_W   = 22;
    localparam int MAG_W    = 21;
    localparam int LOC_W    = 12;
    localparam int CNT_W    = 12;
    localparam int COUNT_W  = 13;

    // Saturation limits.
    localparam int COUNT_LIMIT    = 2 * MAX_SLICE_LENGTH - 1;
    localparam int LOC_MAX        = MAX_SLICE_LENGTH - 1;
    localparam int EDGE_COUNT_MAX = 4095;

    // Configuration port.
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int HW_RESET     = 2;

    typedef enum logic [0:0] {
        REG_HALF_WIDTH     = 1'b0,
        REG_EDGE_THRESHOLD = 1'b1
    } t_reg_idx;

    // Per-cell control: shift the row or clear it.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    // Per-cell tap selects for the centre and far samples.
    typedef struct packed {
        logic mid;
        logic far;
    } t_tap_sel;

    // Transaction handed from the window stage to the evaluator.
    typedef struct packed {
        logic                     last;
        logic                     have_diff;
        logic                     evaluate;
        logic [LOC_W-1:0]         loc;
        logic signed [DIFF_W-1:0] dnew;
    } t_diff_token;

endpackage

// ----- rtl/core/sdd_cell.sv -----
// One cell of the sample window: holds one sample and hands it to its neighbor.
// Depends on sdd_pkg.
module sdd_cell import sdd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctrl          i_ctrl,
    input  t_tap_sel            i_sel,
    input  logic [SAMPLE_W-1:0] i_prev,
    output logic [SAMPLE_W-1:0] o_sample,
    output logic [SAMPLE_W-1:0] o_mid,
    output logic [SAMPLE_W-1:0] o_far
);

    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] n_sample;

    // A last sample empties the row; otherwise each accepted sample moves one place on.
    always_comb begin
        n_sample = r_sample;
        if (i_ctrl.clear) begin
            n_sample = '0;
        end else if (i_ctrl.shift) begin
            n_sample = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    // Gated taps feed the OR trees at the top level.
    assign o_sample = r_sample;
    assign o_mid    = i_sel.mid ? r_sample : '0;
    assign o_far    = i_sel.far ? r_sample : '0;

endmodule

// ----- rtl/core/sdd_eval.sv -----
// Edge evaluator: keeps the last two second differences and the edge counts,
// and holds the result register. Depends on sdd_pkg.
module sdd_eval import sdd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  t_diff_token      i_tok,
    input  logic [THR_W-1:0] i_threshold,
    input  logic             i_stall,
    output logic             o_tok_ready,
    output logic             o_valid,
    output logic             o_falling,
    output logic [LOC_W-1:0] o_location,
    output logic [MAG_W-1:0] o_magnitude,
    output logic [CNT_W-1:0] o_earlier_rising,
    output logic [CNT_W-1:0] o_earlier_falling
);

    logic signed [DIFF_W-1:0] r_diff_before;
    logic signed [DIFF_W-1:0] r_diff_centre;
    logic [CNT_W-1:0]         r_rise_cnt;
    logic [CNT_W-1:0]         r_fall_cnt;
    logic                     r_valid;
    logic                     r_falling;
    logic [LOC_W-1:0]         r_location;
    logic [MAG_W-1:0]         r_magnitude;
    logic [CNT_W-1:0]         r_earlier_rising;
    logic [CNT_W-1:0]         r_earlier_falling;

    logic signed [DIFF_W-1:0] n_diff_before;
    logic signed [DIFF_W-1:0] n_diff_centre;
    logic [CNT_W-1:0]         n_rise_cnt;
    logic [CNT_W-1:0]         n_fall_cnt;
    logic                     n_valid;

    logic                     out_free;
    logic                     fire;
    logic signed [DIFF_W-1:0] thr_pos;
    logic signed [DIFF_W-1:0] thr_neg;
    logic signed [DIFF_W-1:0] e_neg;
    logic                     is_rise;
    logic                     is_fall;
    logic                     produce;

    // The result register is free when empty or being taken in this cycle.
    assign out_free    = !r_valid || !i_stall;
    assign fire        = i_tok_valid && out_free;
    assign o_tok_ready = out_free;

    // Local extreme tests on the pending difference.
    assign thr_pos = $signed({1'b0, i_threshold});
    assign thr_neg = -thr_pos;
    assign e_neg   = -r_diff_centre;
    assign is_rise = (r_diff_centre > thr_pos) && (r_diff_centre > r_diff_before)
                     && (r_diff_centre >= i_tok.dnew);
    assign is_fall = (r_diff_centre < thr_neg) && (r_diff_centre < r_diff_before)
                     && (r_diff_centre <= i_tok.dnew);
    assign produce = fire && !i_tok.last && i_tok.have_diff && i_tok.evaluate
                     && (is_rise || is_fall);

    // Difference history and edge counters.
    always_comb begin
        n_diff_before = r_diff_before;
        n_diff_centre = r_diff_centre;
        n_rise_cnt    = r_rise_cnt;
        n_fall_cnt    = r_fall_cnt;
        if (fire) begin
            if (i_tok.last) begin
                n_diff_before = '0;
                n_diff_centre = '0;
                n_rise_cnt    = '0;
                n_fall_cnt    = '0;
            end else if (i_tok.have_diff) begin
                if (i_tok.evaluate) begin
                    n_diff_before = r_diff_centre;
                    if (is_rise) begin
                        if (r_rise_cnt != CNT_W'(EDGE_COUNT_MAX)) begin
                            n_rise_cnt = r_rise_cnt + 1'b1;
                        end
                    end else if (is_fall) begin
                        if (r_fall_cnt != CNT_W'(EDGE_COUNT_MAX)) begin
                            n_fall_cnt = r_fall_cnt + 1'b1;
                        end
                    end
                end
                n_diff_centre = i_tok.dnew;
            end
        end
    end

    // Result valid: set by a new edge, cleared once the receiver takes it.
    always_comb begin
        n_valid = r_valid;
        if (out_free) begin
            n_valid = produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_before <= '0;
            r_diff_centre <= '0;
            r_rise_cnt    <= '0;
            r_fall_cnt    <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_diff_before <= n_diff_before;
            r_diff_centre <= n_diff_centre;
            r_rise_cnt    <= n_rise_cnt;
            r_fall_cnt    <= n_fall_cnt;
            r_valid       <= n_valid;
        end
    end

    // Result payload, loaded only with a new edge.
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_falling         <= !is_rise;
            r_location        <= i_tok.loc;
            r_magnitude       <= is_rise ? r_diff_centre[MAG_W-1:0] : e_neg[MAG_W-1:0];
            r_earlier_rising  <= r_rise_cnt;
            r_earlier_falling <= r_fall_cnt;
        end
    end

    assign o_valid           = r_valid;
    assign o_falling         = r_falling;
    assign o_location        = r_location;
    assign o_magnitude       = r_magnitude;
    assign o_earlier_rising  = r_earlier_rising;
    assign o_earlier_falling = r_earlier_falling;

endmodule

// ----- rtl/core/second_difference_edge_detector_unit.sv -----
// Top level of the second difference edge detector: configuration registers,
// the window row of sdd_cell instances and the sdd_eval stage. Depends on sdd_pkg.
//
// Usage:
//   Input channel (i_valid, o_stall, i_sample, i_last_sample) carries one sample
//   of a slice per transaction. A sample flagged last is not evaluated and
//   returns the window, sample count, stored differences and edge counts to zero.
//   Output channel (o_valid, i_stall, o_falling, o_location, o_magnitude,
//   o_earlier_rising, o_earlier_falling) carries one transaction per edge found.
//   Throughput is one sample per cycle while the input is not stalled. A sample
//   passes two register stages: the window row with the tap sum, then the edge
//   test into the result register, so an edge shows on the output once the sample
//   that completes it has gone on from the tap sum into the result register.
//   When the receiver stalls, the result holds and one more sample is still
//   taken into the window stage; o_stall rises only while that stage is full
//   behind a held result.
//   Configuration (APB, pready always high): half_width at address 0 and
//   edge_threshold at address 4. The user writes them only while the block
//   is idle; the block itself does not enforce this. Reset (synchronous, active low)
//   sets half_width to 2, edge_threshold to 0 and clears all slice state.
module second_difference_edge_detector_unit import sdd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // Sample channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last_sample,
    // Edge channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_falling,
    output logic [LOC_W-1:0]    o_location,
    output logic [MAG_W-1:0]    o_magnitude,
    output logic [CNT_W-1:0]    o_earlier_rising,
    output logic [CNT_W-1:0]    o_earlier_falling
);

    logic [HW_W-1:0]     r_half_width;
    logic [THR_W-1:0]    r_edge_threshold;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic                r_tok_valid;
    logic                n_tok_valid;
    t_diff_token         r_tok;
    t_diff_token         n_tok;

    logic                cfg_wr;
    t_reg_idx            reg_idx;
    logic                accept;
    logic                tok_ready;
    logic [HW_W-1:0]     w_eff;
    logic [CELL_IDX_W-1:0] mid_idx;
    logic [CELL_IDX_W-1:0] far_idx;
    logic [HW_W:0]       two_w;
    logic [COUNT_W-1:0]  centre;
    logic [SAMPLE_W-1:0] mid_val;
    logic [SAMPLE_W-1:0] far_val;
    t_cell_ctrl          cell_ctrl;

    logic [SAMPLE_W-1:0] cell_sample [CELL_COUNT];
    logic [SAMPLE_W-1:0] cell_mid    [CELL_COUNT];
    logic [SAMPLE_W-1:0] cell_far    [CELL_COUNT];
    t_tap_sel            cell_sel    [CELL_COUNT];

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width     <= HW_W'(HW_RESET);
            r_edge_threshold <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_HALF_WIDTH:     r_half_width     <= pwdata[HW_W-1:0];
                REG_EDGE_THRESHOLD: r_edge_threshold <= pwdata[THR_W-1:0];
                default:            r_half_width     <= r_half_width;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HALF_WIDTH:     prdata = PDATA_W'(r_half_width);
            REG_EDGE_THRESHOLD: prdata = PDATA_W'(r_edge_threshold);
            default:            prdata = '0;
        endcase
    end

    // Effective half width, clamped to 1..MAX_HALF_WIDTH, and the tap positions.
    always_comb begin
        if (r_half_width == '0) begin
            w_eff = HW_W'(1);
        end else if (r_half_width > HW_W'(MAX_HALF_WIDTH)) begin
            w_eff = HW_W'(MAX_HALF_WIDTH);
        end else begin
            w_eff = r_half_width;
        end
    end

    assign two_w   = {w_eff, 1'b0};
    assign mid_idx = CELL_IDX_W'(w_eff - 1'b1);
    assign far_idx = CELL_IDX_W'(two_w - 1'b1);

    // Input handshake.
    assign accept  = i_valid && !o_stall;
    assign o_stall = r_tok_valid && !tok_ready;

    assign cell_ctrl.shift = accept && !i_last_sample;
    assign cell_ctrl.clear = accept && i_last_sample;

    // Row of window cells, newest sample in cell 0.
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        localparam logic [CELL_IDX_W-1:0] CellIdx = CELL_IDX_W'(k);

        assign cell_sel[k].mid = (mid_idx == CellIdx);
        assign cell_sel[k].far = (far_idx == CellIdx);

        if (k == 0) begin : g_head
            sdd_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (cell_ctrl),
                .i_sel    (cell_sel[k]),
                .i_prev   (i_sample),
                .o_sample (cell_sample[k]),
                .o_mid    (cell_mid[k]),
                .o_far    (cell_far[k])
            );
        end else begin : g_body
            sdd_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (cell_ctrl),
                .i_sel    (cell_sel[k]),
                .i_prev   (cell_sample[k-1]),
                .o_sample (cell_sample[k]),
                .o_mid    (cell_mid[k]),
                .o_far    (cell_far[k])
            );
        end
    end

    // Collect the gated taps; exactly one cell drives each.
    always_comb begin
        mid_val = '0;
        far_val = '0;
        for (int k = 0; k < CELL_COUNT; k++) begin
            mid_val = mid_val | cell_mid[k];
            far_val = far_val | cell_far[k];
        end
    end

    // Second difference and the flags for the evaluator.
    assign centre = r_count - COUNT_W'(w_eff) - 1'b1;

    always_comb begin
        n_tok           = r_tok;
        n_tok_valid     = r_tok_valid;
        n_count         = r_count;
        if (tok_ready) begin
            n_tok_valid = 1'b0;
        end
        if (accept) begin
            n_tok_valid     = 1'b1;
            n_tok.last      = i_last_sample;
            n_tok.have_diff = (r_count >= COUNT_W'(two_w));
            n_tok.evaluate  = (r_count > COUNT_W'(two_w));
            n_tok.loc       = (centre > COUNT_W'(LOC_MAX)) ? LOC_W'(LOC_MAX)
                                                           : centre[LOC_W-1:0];
            n_tok.dnew      = $signed(DIFF_W'(i_sample) + DIFF_W'(far_val)
                                      - {1'b0, mid_val, 1'b0});
            if (i_last_sample) begin
                n_count = '0;
            end else if (r_count != COUNT_W'(COUNT_LIMIT)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_tok_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_tok_valid <= n_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    // Edge test and result register.
    sdd_eval u_eval (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tok_valid       (r_tok_valid),
        .i_tok             (r_tok),
        .i_threshold       (r_edge_threshold),
        .i_stall           (i_stall),
        .o_tok_ready       (tok_ready),
        .o_valid           (o_valid),
        .o_falling         (o_falling),
        .o_location        (o_location),
        .o_magnitude       (o_magnitude),
        .o_earlier_rising  (o_earlier_rising),
        .o_earlier_falling (o_earlier_falling)
    );

endmodule

// ----- rtl/core/sdd_checker.sv -----
// Port-level checks for second_difference_edge_detector_unit, attached by bind.
// Depends on sdd_pkg.
module sdd_checker import sdd_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic             o_falling,
    input logic [LOC_W-1:0] o_location,
    input logic [MAG_W-1:0] o_magnitude,
    input logic [CNT_W-1:0] o_earlier_rising,
    input logic [CNT_W-1:0] o_earlier_falling
);

    // Reset leaves no edge transaction pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("edge valid after reset");

    // A stalled edge transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_falling) && $stable(o_location)
        && $stable(o_magnitude) && $stable(o_earlier_rising)
        && $stable(o_earlier_falling))
        else $error("stalled edge transaction changed");

    // Input is held back only behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // An edge always lies strictly past the threshold, so it is never zero.
    a_mag_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_magnitude != '0)
        else $error("edge with zero magnitude");

endmodule

bind second_difference_edge_detector_unit sdd_checker u_sdd_checker (.*);

// ----- tb/tb_second_difference_edge_detector_unit.sv -----
// Self-checking testbench for second_difference_edge_detector_unit: slices of samples in,
// edge transactions out, each compared against an in-bench second difference edge predictor.
// Depends on sdd_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 100ps

module tb_second_difference_edge_detector_unit;
    import sdd_pkg::*;

    localparam int WIN_DEPTH     = 2 * MAX_HALF_WIDTH + 1;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int LATENCY_SLACK = 8;
    localparam int PHASE_ITEMS   = 160;
    localparam int LONG_SLICE    = 400;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_sample_item;

    typedef struct packed {
        logic             falling;
        logic [LOC_W-1:0] loc;
        logic [MAG_W-1:0] mag;
        logic [CNT_W-1:0] rise;
        logic [CNT_W-1:0] fall;
    } t_edge_rec;

    // Clock, reset and block ports.
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample      = '0;
    logic                i_last_sample = 1'b0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic                o_falling;
    logic [LOC_W-1:0]    o_location;
    logic [MAG_W-1:0]    o_magnitude;
    logic [CNT_W-1:0]    o_earlier_rising;
    logic [CNT_W-1:0]    o_earlier_falling;

    // Pending samples, expected edges and run bookkeeping.
    t_sample_item sample_queue[$];
    t_edge_rec    expected_edges[$];
    int           errors      = 0;
    int           cycle_count = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;

    // Predictor copy of the registers and the slice state.
    logic [HW_W-1:0]          cfg_half_width;
    logic [THR_W-1:0]         cfg_threshold;
    logic [SAMPLE_W-1:0]      win_q [WIN_DEPTH];
    logic [COUNT_W-1:0]       smp_count;
    logic signed [DIFF_W-1:0] d_prev;
    logic signed [DIFF_W-1:0] d_pend;
    logic [CNT_W-1:0]         n_rise;
    logic [CNT_W-1:0]         n_fall;

    second_difference_edge_detector_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample          (i_sample),
        .i_last_sample     (i_last_sample),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_falling         (o_falling),
        .o_location        (o_location),
        .o_magnitude       (o_magnitude),
        .o_earlier_rising  (o_earlier_rising),
        .o_earlier_falling (o_earlier_falling)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic clear_slice_state();
        for (int k = 0; k < WIN_DEPTH; k++) begin
            win_q[k] = '0;
        end
        smp_count = '0;
        d_prev    = '0;
        d_pend    = '0;
        n_rise    = '0;
        n_fall    = '0;
    endtask

    // Advance the predictor by one accepted sample and queue the edge it reveals, if any.
    task automatic detect_edge(input logic [SAMPLE_W-1:0] s, input logic last);
        int        w;
        int        n;
        int        c;
        int        dnew;
        int        e;
        int        p;
        int        thr;
        int        s0;
        int        sw;
        int        s2w;
        t_edge_rec r;
        if (last) begin
            clear_slice_state();
            return;
        end
        w = cfg_half_width;
        if (w < 1) w = 1;
        if (w > MAX_HALF_WIDTH) w = MAX_HALF_WIDTH;
        n = smp_count;
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
            win_q[k] = win_q[k-1];
        end
        win_q[0] = s;
        if (n >= 2 * w) begin
            s0   = win_q[0];
            sw   = win_q[w];
            s2w  = win_q[2*w];
            dnew = s0 + s2w - 2 * sw;
            if (n > 2 * w) begin
                // The pending difference is now flanked on both sides: test it.
                c   = n - w - 1;
                e   = d_pend;
                p   = d_prev;
                thr = cfg_threshold;
                r.loc  = LOC_W'((c > LOC_MAX) ? LOC_MAX : c);
                r.rise = n_rise;
                r.fall = n_fall;
                if (e > thr && e > p && e >= dnew) begin
                    r.falling = 1'b0;
                    r.mag     = MAG_W'(e);
                    expected_edges.insert(expected_edges.size(), r);
                    if (n_rise != CNT_W'(EDGE_COUNT_MAX)) n_rise++;
                end else if (e < -thr && e < p && e <= dnew) begin
                    r.falling = 1'b1;
                    r.mag     = MAG_W'(-e);
                    expected_edges.insert(expected_edges.size(), r);
                    if (n_fall != CNT_W'(EDGE_COUNT_MAX)) n_fall++;
                end
                d_prev = d_pend;
            end
            d_pend = DIFF_W'(dnew);
        end
        if (smp_count < COUNT_LIMIT) smp_count++;
    endtask

    // Sample driver: presents queued transactions and feeds each accepted one to the predictor.
    always @(posedge i_clk) begin
        t_sample_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                detect_edge(i_sample, i_last_sample);
            end
            if (!i_valid || !o_stall) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = sample_queue.pop_front();
                    i_valid       <= 1'b1;
                    i_sample      <= nxt.sample;
                    i_last_sample <= nxt.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Edge monitor: random back-pressure and field-by-field comparison.
    always @(posedge i_clk) begin
        t_edge_rec want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_edges.size() == 0) begin
                    note_failure($sformatf("unexpected edge at %0t: falling=%0d loc=%0d mag=%0d",
                                           $time, o_falling, o_location, o_magnitude));
                end else begin
                    want = expected_edges.pop_front();
                    if (o_falling !== want.falling || o_location !== want.loc ||
                        o_magnitude !== want.mag || o_earlier_rising !== want.rise ||
                        o_earlier_falling !== want.fall) begin
                        note_failure($sformatf({"edge mismatch at %0t: expected falling=%0d ",
                            "loc=%0d mag=%0d rise=%0d fall=%0d, got falling=%0d loc=%0d ",
                            "mag=%0d rise=%0d fall=%0d"}, $time, want.falling, want.loc,
                            want.mag, want.rise, want.fall, o_falling, o_location,
                            o_magnitude, o_earlier_rising, o_earlier_falling));
                    end
                end
            end
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Run time limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Read a register and compare it with the value it should hold.
    task automatic check_register(input t_reg_idx idx, input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            note_failure($sformatf("register %s read %0d, expected %0d",
                                   idx.name(), got, want));
        end
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [PDATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_HALF_WIDTH:     cfg_half_width = val[HW_W-1:0];
            REG_EDGE_THRESHOLD: cfg_threshold  = val[THR_W-1:0];
            default: ;
        endcase
        check_register(idx, val);
    endtask

    // Wait until every sample is taken and every expected edge has arrived, then let
    // the pipeline run empty. The driver's updates for an edge are looked at only
    // after they have landed.
    task automatic settle();
        int guard;
        do begin
            @(posedge i_clk);
            #1;
        end while (sample_queue.size() != 0 || i_valid);
        for (guard = 0; guard < DRAIN_LIMIT && expected_edges.size() != 0; guard++) begin
            @(posedge i_clk);
        end
        if (expected_edges.size() != 0) begin
            note_failure($sformatf("%0d expected edges never arrived",
                                   expected_edges.size()));
            expected_edges.delete();
        end
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
            default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
        endcase
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic last);
        t_sample_item itm;
        itm.sample = s;
        itm.last   = last;
        sample_queue.insert(sample_queue.size(), itm);
    endtask

    // Queue one slice: mostly running integrals of a piecewise constant intensity,
    // otherwise noise or rail-to-rail values. Returns the number of samples queued.
    task automatic queue_slice(input int len, input bit close, output int queued);
        int                  mode;
        int                  level;
        logic [SAMPLE_W-1:0] acc;
        mode  = $urandom_range(9);
        acc   = ($urandom_range(3) == 0) ? SAMPLE_W'($urandom) : '0;
        level = $urandom_range(0, 4096);
        for (int k = 0; k < len; k++) begin
            if (mode < 6) begin
                if ($urandom_range(7) == 0) begin
                    level = $urandom_range(0, 1 << $urandom_range(2, 14));
                end
                acc = acc + SAMPLE_W'(level);
                push_sample(acc, 1'b0);
            end else if (mode < 8) begin
                push_sample(SAMPLE_W'($urandom), 1'b0);
            end else begin
                push_sample($urandom_range(1) ? '1 : '0, 1'b0);
            end
        end
        queued = len;
        if (close) begin
            push_sample(SAMPLE_W'($urandom), 1'b1);
            queued++;
        end
    endtask

    initial begin
        int phase_width;
        int phase_thr;
        int phase_count;
        int got;
        int len;
        clear_slice_state();
        cfg_half_width = HW_W'(HW_RESET);
        cfg_threshold  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers.
        check_register(REG_HALF_WIDTH, PDATA_W'(HW_RESET));
        check_register(REG_EDGE_THRESHOLD, '0);

        // Directed slice at reset settings: rail steps up and down give rising and
        // falling edges, flat stretches give ties, the first difference is only stored.
        set_idle_mode(0);
        push_sample('0, 1'b0);
        push_sample('0, 1'b0);
        push_sample('0, 1'b0);
        push_sample('0, 1'b0);
        push_sample('1, 1'b0);
        push_sample('1, 1'b0);
        push_sample('1, 1'b0);
        push_sample('1, 1'b0);
        push_sample('0, 1'b0);
        push_sample('0, 1'b0);
        push_sample('0, 1'b0);
        push_sample('0, 1'b0);
        push_sample(20'h55555, 1'b0);
        push_sample(20'hAAAAA, 1'b0);
        push_sample(20'h55555, 1'b0);
        push_sample(20'hAAAAA, 1'b0);
        push_sample('1, 1'b1);
        // Short slice that never forms a difference and ends on a rail value.
        push_sample(20'h12345, 1'b0);
        push_sample('1, 1'b0);
        push_sample(20'h00001, 1'b0);
        push_sample('0, 1'b1);
        settle();

        // Random phases over several register settings; some slices stay open across a
        // phase boundary so the width changes mid-slice.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin phase_width = 1;  phase_thr = 0;       end
                1: begin phase_width = 16; phase_thr = 2097151; end
                2: begin phase_width = 0;  phase_thr = $urandom_range(0, 1000); end
                3: begin phase_width = 31; phase_thr = 0;       end
                4: begin
                    phase_width = $urandom_range(17, 30);
                    phase_thr   = $urandom_range(0, 50000);
                end
                5: begin
                    phase_width = $urandom_range(1, 16);
                    phase_thr   = $urandom_range(0, 200000);
                end
                6: begin
                    phase_width = $urandom_range(1, 16);
                    phase_thr   = $urandom_range(0, 5000);
                end
                default: begin
                    phase_width = $urandom_range(3, 8);
                    phase_thr   = $urandom_range(0, 20000);
                end
            endcase
            write_register(REG_HALF_WIDTH, PDATA_W'(phase_width));
            write_register(REG_EDGE_THRESHOLD, PDATA_W'(phase_thr));
            set_idle_mode(phase % 4);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(61, 300) : $urandom_range(4, 60);
                queue_slice(len, ($urandom_range(99) < 85), got);
                phase_count += got;
            end
            settle();

            // One long zig-zag slice: an edge at every centre drives both edge counts
            // well up and alternates the polarity on every transaction.
            if (phase == 3) begin
                write_register(REG_HALF_WIDTH, PDATA_W'(1));
                write_register(REG_EDGE_THRESHOLD, '0);
                set_idle_mode(3);
                push_sample('0, 1'b1);
                for (int k = 0; k < LONG_SLICE; k++) begin
                    push_sample((k % 2 == 0) ? SAMPLE_W'($urandom_range(0, 20'h3FFFF))
                                             : SAMPLE_W'($urandom_range(20'h80000, 20'hFFFFF)),
                                1'b0);
                end
                push_sample(SAMPLE_W'($urandom), 1'b1);
                settle();
            end
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
